// ===== design/rkss_pkg.sv =====
// Shared constants and types for the running k-smallest-sum block.
// Used by the sorted cell chain and the top level; no dependencies.
package rkss_pkg;

    // Store geometry and field widths.
    localparam int VALUE_W = 32;
    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEEP_W  = 7;
    localparam int SUM_W   = 38;
    localparam int DELTA_W = VALUE_W + 1;

    // Register port geometry: one 32-bit register per word.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes and reset values.
    localparam logic [REG_IDX_W-1:0] REG_K_KEEP   = '0;
    localparam logic [KEEP_W-1:0]    K_KEEP_RESET = KEEP_W'(1);

    // What a cell hands to its right neighbor: its held value and whether
    // that value is in use and larger than the incoming sample.
    typedef struct packed {
        logic                      gt;
        logic signed [VALUE_W-1:0] val;
    } rkss_link_t;

endpackage

// ===== design/rkss_cell.sv =====
// One cell of the descending sorted store: holds a single value.
// Depends on rkss_pkg for widths and the neighbor link type.
module rkss_cell (
    input  logic                               clk,
    input  logic                               load,
    input  logic                               evict,
    input  logic                               in_use,
    input  logic signed [rkss_pkg::VALUE_W-1:0] sample,
    input  rkss_pkg::rkss_link_t               left,
    input  logic signed [rkss_pkg::VALUE_W-1:0] right_ins,
    output rkss_pkg::rkss_link_t               link,
    output logic signed [rkss_pkg::VALUE_W-1:0] ins
);
    import rkss_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      gt;

    // A held value larger than the sample stays; the first cell that is not
    // larger takes the sample, and the cells after it take the left value.
    assign gt  = in_use && (val_reg > sample);
    assign ins = gt ? val_reg : (left.gt ? sample : left.val);

    // On an eviction the largest value leaves at cell 0 and the row shifts left.
    assign val_next = evict ? right_ins : ins;

    assign link.gt  = gt;
    assign link.val = val_reg;

    // Payload register, written only when a beat is taken.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
        end
    end

endmodule

// ===== design/running_k_smallest_sum.sv =====
// Top level of the running k-smallest-sum block: register port, cell row,
// count and sum pipeline. Depends on rkss_pkg and rkss_cell.
//
// Usage:
//   Input channel (in_valid, in_stall, value, restart) carries one signed
//   sample per beat; restart empties the store and zeroes the sum before the
//   sample is inserted. Output channel (out_valid, out_stall, sum, full_res)
//   returns one beat per input beat, in order: the sum of the kept values and
//   a flag that is set when exactly k_keep values (at most 64) are held.
//   The register k_keep lies at byte address 0 of the APB port and must be
//   written while the block is idle; the block itself does not enforce this.
//   pready is always high. An input beat passes the cell row into the
//   middle stage, then the sum register. One input beat is taken every cycle
//   while the receiver does not stall: each cell compares against the broadcast
//   sample to sort it, and the sum is added in the following stage.
//   Reset empties the store and zeroes the sum at once and sets k_keep to 1;
//   the block takes beats from the first cycle after reset.
//   When the receiver stalls, the result waits in the output register, one
//   more beat is taken into the middle stage, and then in_stall rises.
module running_k_smallest_sum (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rkss_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [rkss_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rkss_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rkss_pkg::VALUE_W-1:0]    value,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rkss_pkg::SUM_W-1:0]      sum,
    output logic                                  full_res
);
    import rkss_pkg::*;

    logic [KEEP_W-1:0]          k_keep_reg;
    logic [KEEP_W-1:0]          k_keep_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic                       restart_s1_reg;
    logic                       full_s1_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       full_out_reg;

    logic [REG_IDX_W-1:0]       reg_idx;
    logic                       cfg_write;
    logic                       accept;
    logic                       s1_move;
    logic [CNT_W-1:0]           n_eff;
    logic [CNT_W-1:0]           k_eff;
    logic [CNT_W-1:0]           n_new;
    logic                       evict;
    logic                       full_new;
    logic signed [VALUE_W-1:0]  evicted;
    logic signed [VALUE_W-1:0]  tail_ins;
    logic signed [DELTA_W-1:0]  delta_new;
    logic signed [SUM_W-1:0]    sum_base;

    rkss_link_t                 link [DEPTH];
    logic signed [VALUE_W-1:0]  ins  [DEPTH];
    logic [DEPTH-1:0]           in_use;

    // Register port: a single register, always ready.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_K_KEEP) ? APB_DATA_W'(k_keep_reg) : '0;
    assign k_keep_next = (cfg_write && (reg_idx == REG_K_KEEP))
                       ? pwdata[KEEP_W-1:0] : k_keep_reg;

    // Handshake: the middle stage moves on when the output register is free.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    // Held count seen by this sample, and the limit saturated to the depth.
    assign n_eff = restart ? '0 : count_reg;
    assign k_eff = (k_keep_reg > KEEP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(k_keep_reg);

    // One more than the limit after insertion means the largest leaves.
    assign evict    = (n_eff >= k_eff);
    assign n_new    = evict ? n_eff : n_eff + CNT_W'(1);
    assign full_new = (n_new == k_eff);

    // Cells below the held count carry valid values.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            in_use[i] = (CNT_W'(i) < n_eff);
        end
    end

    // Row of cells, largest value in cell 0.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : gen_cell
            rkss_link_t                left_link;
            logic signed [VALUE_W-1:0] right_val;

            if (g == 0)
            begin : gen_head
                assign left_link.gt  = 1'b1;
                assign left_link.val = value;
            end
            else
            begin : gen_body
                assign left_link = link[g-1];
            end

            if (g == DEPTH - 1)
            begin : gen_tail
                assign right_val = tail_ins;
            end
            else
            begin : gen_mid
                assign right_val = ins[g+1];
            end

            rkss_cell u_cell (
                .clk       (clk),
                .load      (accept),
                .evict     (evict),
                .in_use    (in_use[g]),
                .sample    (value),
                .left      (left_link),
                .right_ins (right_val),
                .link      (link[g]),
                .ins       (ins[g])
            );
        end
    endgenerate

    // Slot past the last cell: only reached when the row is full.
    assign tail_ins = link[DEPTH-1].gt ? value : link[DEPTH-1].val;

    // The largest of the held values and the sample leaves through cell 0.
    assign evicted   = ins[0];
    assign delta_new = evict ? (DELTA_W'(value) - DELTA_W'(evicted)) : DELTA_W'(value);

    // Second stage: fold the change into the running sum.
    assign sum_base = restart_s1_reg ? '0 : sum_reg;
    assign sum_next = s1_move ? (sum_base + SUM_W'(delta_reg)) : sum_reg;

    // Next-state logic for control.
    assign count_next     = accept ? n_new : count_reg;
    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_keep_reg    <= K_KEEP_RESET;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            k_keep_reg    <= k_keep_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
        end
    end

    // Payload registers of the middle and output stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            delta_reg      <= delta_new;
            restart_s1_reg <= restart;
            full_s1_reg    <= full_new;
        end
        if (s1_move)
        begin
            full_out_reg <= full_s1_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign full_res  = full_out_reg;

endmodule

// ===== tb/sv/rkss_sum_checker.sv =====
`timescale 1ns / 1ps
// Checker for the running k-smallest-sum block. It follows k_keep writes on the APB port,
// predicts the sum and full flag for every input beat, and compares the output beats.
// Depends on rkss_pkg.
module rkss_sum_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [rkss_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rkss_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [rkss_pkg::VALUE_W-1:0]  value,
    input  logic                                 restart,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [rkss_pkg::SUM_W-1:0]    sum,
    input  logic                                 full_res,
    output int                                   pending,
    output int                                   errors
);
    import rkss_pkg::*;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    full;
    } sum_beat_t;

    // Private copy of the block state: sorted kept values, count, sum and k_keep.
    logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
    int unsigned               held_n;
    logic [SUM_W-1:0]          acc;
    logic [KEEP_W-1:0]         keep_k;
    sum_beat_t                 sums_due [$];
    sum_beat_t                 want;
    int                        fail_n;

    function automatic logic [SUM_W-1:0] widen(input logic signed [VALUE_W-1:0] v);
        return {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
    endfunction

    // Insert into entries 0..n, after any equal values already held.
    function automatic void place_sorted(input logic signed [VALUE_W-1:0] v,
                                         input int unsigned n);
        int unsigned i;
        i = n;
        while (i > 0 && sorted_vals[i-1] > v) begin
            sorted_vals[i] = sorted_vals[i-1];
            i--;
        end
        sorted_vals[i] = v;
    endfunction

    // Advance the state by one sample and return the result it produces.
    function automatic sum_beat_t next_sum(input logic signed [VALUE_W-1:0] v, input logic r);
        sum_beat_t   res;
        int unsigned k_eff;
        k_eff = (keep_k > DEPTH) ? DEPTH : keep_k;
        if (r) begin
            held_n = 0;
            acc    = '0;
        end
        if (held_n < DEPTH) begin
            place_sorted(v, held_n);
            held_n++;
            acc = acc + widen(v);
            // Only one value leaves per sample, even when k_keep was lowered.
            if (held_n > k_eff) begin
                held_n--;
                acc = acc - widen(sorted_vals[held_n]);
            end
        end else if (v < sorted_vals[DEPTH-1]) begin
            // Store full: the largest held value makes room for the sample.
            acc = acc - widen(sorted_vals[DEPTH-1]);
            place_sorted(v, DEPTH - 1);
            acc = acc + widen(v);
        end
        res.sum  = acc;
        res.full = (held_n == k_eff);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_n  = 0;
            acc     = '0;
            keep_k  = K_KEEP_RESET;
            fail_n  = 0;
            sums_due.delete();
            pending <= 0;
            errors  <= 0;
        end else begin
            // Register write completes in the access phase.
            if (psel && penable && pwrite && pready
                    && paddr[APB_ADDR_W-1:2] == REG_K_KEEP) begin
                keep_k = pwdata[KEEP_W-1:0];
            end

            // Queue the expected result of each accepted input beat at the tail.
            if (in_valid && !in_stall) begin
                sums_due.insert(sums_due.size(), next_sum(value, restart));
            end

            // Each output beat answers the oldest input beat still waiting.
            if (out_valid && !out_stall) begin
                if (sums_due.size() == 0) begin
                    $error("output beat arrived with no input beat waiting");
                    fail_n++;
                end else begin
                    want = sums_due.pop_front();
                    if (sum !== want.sum) begin
                        $error("sum mismatch: expected %0d, actual %0d",
                               $signed(want.sum), $signed(sum));
                        fail_n++;
                    end
                    if (full_res !== want.full) begin
                        $error("full_res mismatch: expected %0b, actual %0b",
                               want.full, full_res);
                        fail_n++;
                    end
                end
            end

            pending <= sums_due.size();
            errors  <= fail_n;
        end
    end

endmodule

// ===== tb/sv/tb_running_k_smallest_sum.sv =====
`timescale 1ns / 1ps
// Top of the running k-smallest-sum testbench: clock, reset, stimulus and verdict.
// Depends on rkss_pkg, running_k_smallest_sum and rkss_sum_checker.
module tb_running_k_smallest_sum;
    import rkss_pkg::*;

    localparam logic signed [VALUE_W-1:0] MAX_VAL = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] MIN_VAL = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam int BEATS_PER_SETTING = 86;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]        paddr    = '0;
    logic [APB_DATA_W-1:0]        pwdata   = '0;
    logic [APB_DATA_W-1:0]        prdata;
    logic                         pready;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [VALUE_W-1:0]    value    = '0;
    logic                         restart  = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SUM_W-1:0]      sum;
    logic                         full_res;

    int          pending;
    int          errors;
    int          beats_sent  = 0;
    int          phases_run  = 0;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int unsigned regime_left = 0;
    int unsigned tick        = 0;
    int unsigned keep_plan [11] = '{2, 64, 5, 127, 1, 0, 16, 65, 33, 3, 64};

    always #5 clk = ~clk;

    running_k_smallest_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum       (sum),
        .full_res  (full_res)
    );

    rkss_sum_checker checker_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum       (sum),
        .full_res  (full_res),
        .pending   (pending),
        .errors    (errors)
    );

    // Receiver stalls in regimes of random length: none, light, heavy or a fixed comb.
    always @(posedge clk) begin
        if (regime_left == 0) begin
            stall_mode  <= stall_mode_t'($urandom_range(0, 3));
            regime_left <= $urandom_range(40, 300);
        end else begin
            regime_left <= regime_left - 1;
        end
        tick <= tick + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= tick[2];
        endcase
    end

    // Send one beat, opening a gap first whenever the current burst has run out.
    task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic r);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        value    <= v;
        restart  <= r;
        do @(posedge clk); while (in_stall);
        burst_left--;
        beats_sent++;
    endtask

    // Stop sending and wait until every result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of k_keep; the bits above the register carry noise.
    task automatic write_keep(input logic [KEEP_W-1:0] k);
        logic [APB_DATA_W-1:0] noise;
        noise = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_K_KEEP, 2'b00};
        pwdata  <= {noise[APB_DATA_W-1:KEEP_W], k};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phases_run++;
    endtask

    // Full-range, right-shifted, small repeating and near-extreme sample values.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 200) - 100;
            7:          v = $urandom_range(0, 1) ? MAX_VAL : MIN_VAL;
            8:          v = $urandom_range(0, 1) ? MAX_VAL - $urandom_range(0, 15)
                                                 : MIN_VAL + $urandom_range(0, 15);
            default:    v = $signed($urandom) >>> $urandom_range(0, 30);
        endcase
        return v;
    endfunction

    initial begin
        logic wide;
        logic r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset k_keep of 1 only the smallest value survives.
        send_beat(0, 1'b1);
        send_beat(MAX_VAL, 1'b0);
        send_beat(MIN_VAL, 1'b0);
        send_beat(MIN_VAL, 1'b0);
        send_beat(-1, 1'b1);

        // Four of the largest, then four of the smallest values: both ends of the sum.
        settle();
        write_keep(4);
        for (int i = 0; i < 4; i++) send_beat(MAX_VAL, i == 0);
        for (int i = 0; i < 4; i++) send_beat(MIN_VAL, 1'b0);

        // Equal values, then a smaller one that pushes one of them out.
        send_beat(5, 1'b1);
        for (int i = 0; i < 3; i++) send_beat(5, 1'b0);
        send_beat(3, 1'b0);

        // k_keep of zero: every sample leaves at once and the flag stays set.
        settle();
        write_keep(0);
        send_beat(7, 1'b1);
        send_beat(-9, 1'b0);

        // Lowering k_keep below the held count without a restart.
        settle();
        write_keep(4);
        for (int i = 1; i <= 4; i++) send_beat(i, i == 1);
        settle();
        write_keep(2);
        send_beat(0, 1'b0);
        send_beat(9, 1'b0);
        send_beat(6, 1'b1);

        // Random streams over a range of k_keep settings, including saturation.
        foreach (keep_plan[p]) begin
            settle();
            write_keep(KEEP_W'(keep_plan[p]));
            wide = (keep_plan[p] >= DEPTH);
            for (int n = 0; n < BEATS_PER_SETTING; n++) begin
                if (n == 0)
                    r = wide || ($urandom_range(0, 1) == 1);
                else if (wide)
                    r = ($urandom_range(0, 249) == 0);
                else
                    r = ($urandom_range(0, 24) == 0);
                send_beat(pick_value(), r);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d input beats across %0d k_keep writes, covering k of zero,",
                 beats_sent, phases_run);
        $display("k above the store depth, a full store and k lowered without restart.");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
